>>> rtl/mp2d_pkg.sv
package mp2d_pkg;

   // Sizing of the line store and the data path
   localparam int DATA_BITS   = 16;
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_KERNEL  = 8;

   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int DIM_BITS    = COL_BITS + 1;
   localparam int KER_BITS    = $clog2(MAX_KERNEL + 1);
   localparam int SLOT_BITS   = $clog2(MAX_KERNEL);
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_KERNEL;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int STEP_BITS   = 4;
   localparam int SUM_BITS    = $clog2(MAX_WIDTH + MAX_KERNEL + 16);
   localparam int OUT_BITS    = 8;

   // Register file
   localparam int REG_DIM_BITS  = 9;
   localparam int REG_KER_BITS  = 4;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 3;

   localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_KERNEL_WIDTH  = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_KERNEL_HEIGHT = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_STEP_SIZE     = 3'd4;

   // Effective (clamped) configuration
   typedef struct packed {
      logic [DIM_BITS-1:0]  width;
      logic [DIM_BITS-1:0]  height;
      logic [KER_BITS-1:0]  kwidth;
      logic [KER_BITS-1:0]  kheight;
      logic [STEP_BITS-1:0] step;
   } cfg_type;

   // Window found by the position tracker for the sample just taken
   typedef struct packed {
      logic                 hit;
      logic [SLOT_BITS-1:0] slot;
      logic [COL_BITS-1:0]  c0;
      logic [OUT_BITS-1:0]  orow;
      logic [OUT_BITS-1:0]  ocol;
      logic                 last;
   } win_type;

   // Finished window maximum offered by the scan sequencer
   typedef struct packed {
      logic                 valid;
      logic [DATA_BITS-1:0] pooled;
      logic [OUT_BITS-1:0]  orow;
      logic [OUT_BITS-1:0]  ocol;
      logic                 last;
   } res_type;

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_READ,
      SCAN_DRAIN,
      SCAN_EMIT
   } scan_state_type;

   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [REG_DIM_BITS-1:0] v);
      logic [DIM_BITS-1:0] r;
      if (v == '0) begin
         r = DIM_BITS'(1);
      end else if (int'(v) > MAX_WIDTH) begin
         r = DIM_BITS'(MAX_WIDTH);
      end else begin
         r = DIM_BITS'(v);
      end
      return r;
   endfunction

   function automatic logic [KER_BITS-1:0] clamp_ker(input logic [REG_KER_BITS-1:0] v);
      logic [KER_BITS-1:0] r;
      if (v == '0) begin
         r = KER_BITS'(1);
      end else if (int'(v) > MAX_KERNEL) begin
         r = KER_BITS'(MAX_KERNEL);
      end else begin
         r = KER_BITS'(v);
      end
      return r;
   endfunction

   function automatic logic [STEP_BITS-1:0] clamp_step(input logic [REG_KER_BITS-1:0] v);
      logic [STEP_BITS-1:0] r;
      if (v == '0) begin
         r = STEP_BITS'(1);
      end else begin
         r = STEP_BITS'(v);
      end
      return r;
   endfunction

endpackage

>>> rtl/max_pool_2d_stream_unit.sv
// Streaming 2-D max pooling over one channel plane at a time. Send the plane's
// signed Q8.8 samples in raster order on the req_ channel; each window of
// kernel_height x kernel_width placed at a step_size multiple produces one
// rsp_ transfer with its maximum, output row and column, and rsp_last_in_plane
// set on the plane's final window. Windows that do not fit are dropped, and a
// kernel larger than the image produces no output. Planes follow each other
// without a gap; any write to a defined register restarts the plane, so write
// registers only between planes with the block idle. A sample that closes no
// window does not stall the input. A sample that closes a window stalls it
// while the window is read from the line store (2048 x 16, one write port
// and one read port) one entry per cycle through one shared compare unit,
// and until its maximum is taken, which waits while the rsp_ side holds a
// previous result under stall.
// The line store needs no clearing pass after reset; req_stall stays high while
// a window is scanned.
module max_pool_2d_stream_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // input channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [mp2d_pkg::DATA_BITS-1:0]  req_sample,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [mp2d_pkg::DATA_BITS-1:0]  rsp_pooled,
   output logic [mp2d_pkg::OUT_BITS-1:0]          rsp_out_row,
   output logic [mp2d_pkg::OUT_BITS-1:0]          rsp_out_col,
   output logic                                   rsp_last_in_plane,
   // configuration port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [mp2d_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [mp2d_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [mp2d_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                   csr_pready
);
   import mp2d_pkg::*;

   // Raw register values as written
   logic [REG_DIM_BITS-1:0] image_width_ff;
   logic [REG_DIM_BITS-1:0] image_height_ff;
   logic [REG_KER_BITS-1:0] kernel_width_ff;
   logic [REG_KER_BITS-1:0] kernel_height_ff;
   logic [REG_KER_BITS-1:0] step_size_ff;

   logic [REG_IDX_BITS-1:0] csr_index;
   logic                    csr_write;
   logic                    cfg_clear;
   cfg_type                 cfg;

   logic                    req_accept;
   logic                    scan_start;
   logic                    scan_busy;
   logic                    res_take;
   win_type                 win;
   res_type                 res;

   logic [ADDR_BITS-1:0]    wr_addr;
   logic                    rd_en;
   logic [ADDR_BITS-1:0]    rd_addr;
   logic [DATA_BITS-1:0]    rd_data;

   logic                    rsp_valid_ff;
   logic [DATA_BITS-1:0]    rsp_pooled_ff;
   logic [OUT_BITS-1:0]     rsp_out_row_ff;
   logic [OUT_BITS-1:0]     rsp_out_col_ff;
   logic                    rsp_last_ff;

   // ---------------------------------------------------------------------
   // Register file: write on the access phase, restart the plane on any
   // write to a defined register.
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_clear = 1'b0;
      unique case (csr_index)
         REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_KERNEL_WIDTH,
         REG_KERNEL_HEIGHT, REG_STEP_SIZE: begin
            cfg_clear = csr_write;
         end
         default: begin
            cfg_clear = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= REG_DIM_BITS'(32);
         image_height_ff  <= REG_DIM_BITS'(32);
         kernel_width_ff  <= REG_KER_BITS'(2);
         kernel_height_ff <= REG_KER_BITS'(2);
         step_size_ff     <= REG_KER_BITS'(2);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:   image_width_ff   <= csr_pwdata[REG_DIM_BITS-1:0];
            REG_IMAGE_HEIGHT:  image_height_ff  <= csr_pwdata[REG_DIM_BITS-1:0];
            REG_KERNEL_WIDTH:  kernel_width_ff  <= csr_pwdata[REG_KER_BITS-1:0];
            REG_KERNEL_HEIGHT: kernel_height_ff <= csr_pwdata[REG_KER_BITS-1:0];
            REG_STEP_SIZE:     step_size_ff     <= csr_pwdata[REG_KER_BITS-1:0];
            default: begin
               // drop writes to undefined addresses
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_IMAGE_WIDTH:   csr_prdata = CSR_DATA_BITS'(image_width_ff);
         REG_IMAGE_HEIGHT:  csr_prdata = CSR_DATA_BITS'(image_height_ff);
         REG_KERNEL_WIDTH:  csr_prdata = CSR_DATA_BITS'(kernel_width_ff);
         REG_KERNEL_HEIGHT: csr_prdata = CSR_DATA_BITS'(kernel_height_ff);
         REG_STEP_SIZE:     csr_prdata = CSR_DATA_BITS'(step_size_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // Clamp out-of-range sizes before anything uses them
   always_comb begin
      cfg.width   = clamp_dim(image_width_ff);
      cfg.height  = clamp_dim(image_height_ff);
      cfg.kwidth  = clamp_ker(kernel_width_ff);
      cfg.kheight = clamp_ker(kernel_height_ff);
      cfg.step    = clamp_step(step_size_ff);
   end

   // ---------------------------------------------------------------------
   // Input side: take a sample only while no window is being scanned. The
   // sample goes into the line store in the cycle it is taken.
   // ---------------------------------------------------------------------
   assign req_stall  = scan_busy;
   assign req_accept = req_valid && !req_stall;
   assign scan_start = req_accept && win.hit;

   mp2d_position u_position (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .clear   (cfg_clear),
      .accept  (req_accept),
      .win     (win),
      .wr_addr (wr_addr)
   );

   mp2d_ram #(
      .WIDTH (DATA_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (wr_addr),
      .wr_data (req_sample),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mp2d_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .start   (scan_start),
      .win     (win),
      .take    (res_take),
      .rd_data (rd_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .busy    (scan_busy),
      .res     (res)
   );

   // ---------------------------------------------------------------------
   // Output register: load a finished maximum when the register is empty or
   // its current transfer completes this cycle; otherwise hold.
   // ---------------------------------------------------------------------
   assign res_take = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid && res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid && res_take) begin
         rsp_pooled_ff  <= res.pooled;
         rsp_out_row_ff <= res.orow;
         rsp_out_col_ff <= res.ocol;
         rsp_last_ff    <= res.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pooled        = rsp_pooled_ff;
   assign rsp_out_row       = rsp_out_row_ff;
   assign rsp_out_col       = rsp_out_col_ff;
   assign rsp_last_in_plane = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------

   // A sample that closes a window must hold off the next one
   a_hit_stalls: assert property (@(posedge clock) disable iff (reset)
      scan_start |=> req_stall)
      else $error("window hit did not stall the input");

   // A new result appears only out of the scan's emit state
   a_rsp_from_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(res.valid))
      else $error("result valid without a finished scan");

   // No line-store read while a sample is being written
   a_no_read_on_write: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !rd_en)
      else $error("line store read collides with sample write");

endmodule

>>> rtl/mp2d_ram.sv
module mp2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/mp2d_position.sv
module mp2d_position (
   input  logic                           clock,
   input  logic                           reset,
   input  mp2d_pkg::cfg_type              cfg,
   input  logic                           clear,
   input  logic                           accept,
   output mp2d_pkg::win_type              win,
   output logic [mp2d_pkg::ADDR_BITS-1:0] wr_addr
);
   import mp2d_pkg::*;

   logic [COL_BITS-1:0]  row_ff, row_in;
   logic [COL_BITS-1:0]  col_ff, col_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [SUM_BITS-1:0]  nr0_ff, nr0_in;
   logic [SUM_BITS-1:0]  nc0_ff, nc0_in;
   logic [OUT_BITS-1:0]  orow_ff, orow_in;
   logic [OUT_BITS-1:0]  ocol_ff, ocol_in;

   logic [SUM_BITS-1:0]  col_x, row_x, kw_x, kh_x, w_x, h_x, st_x, c0_x, r0_x;
   logic [SLOT_BITS-1:0] slot_nxt;
   logic                 col_ok, row_ok, fit, col_hit, row_hit, row_end, plane_end;

   always_comb begin
      col_x = SUM_BITS'(col_ff) + SUM_BITS'(1);
      row_x = SUM_BITS'(row_ff) + SUM_BITS'(1);
      kw_x  = SUM_BITS'(cfg.kwidth);
      kh_x  = SUM_BITS'(cfg.kheight);
      w_x   = SUM_BITS'(cfg.width);
      h_x   = SUM_BITS'(cfg.height);
      st_x  = SUM_BITS'(cfg.step);
      c0_x  = col_x - kw_x;
      r0_x  = row_x - kh_x;

      col_ok  = col_x >= kw_x;
      row_ok  = row_x >= kh_x;
      fit     = (kw_x <= w_x) && (kh_x <= h_x);
      col_hit = col_ok && (c0_x == nc0_ff);
      row_hit = row_ok && (r0_x == nr0_ff);

      row_end   = col_x == w_x;
      plane_end = row_x == h_x;

      // Oldest row of the window sits one slot past the current one
      slot_nxt = ((KER_BITS'(slot_ff) + KER_BITS'(1)) == cfg.kheight) ? '0
                                                                      : slot_ff + 1'b1;

      win.hit  = fit && col_hit && row_hit;
      win.slot = slot_nxt;
      win.c0   = COL_BITS'(c0_x);
      win.orow = orow_ff;
      win.ocol = ocol_ff;
      win.last = ((r0_x + st_x + kh_x) > h_x) && ((c0_x + st_x + kw_x) > w_x);

      wr_addr = ADDR_BITS'(slot_ff * MAX_WIDTH) + ADDR_BITS'(col_ff);
   end

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      slot_in = slot_ff;
      nr0_in  = nr0_ff;
      nc0_in  = nc0_ff;
      orow_in = orow_ff;
      ocol_in = ocol_ff;
      if (clear) begin
         row_in  = '0;
         col_in  = '0;
         slot_in = '0;
         nr0_in  = '0;
         nc0_in  = '0;
         orow_in = '0;
         ocol_in = '0;
      end else if (accept) begin
         if (win.hit) begin
            nc0_in  = nc0_ff + st_x;
            ocol_in = ocol_ff + 1'b1;
         end
         if (row_end) begin
            col_in  = '0;
            nc0_in  = '0;
            ocol_in = '0;
            if (row_hit) begin
               nr0_in  = nr0_ff + st_x;
               orow_in = orow_ff + 1'b1;
            end
            if (plane_end) begin
               row_in  = '0;
               slot_in = '0;
               nr0_in  = '0;
               orow_in = '0;
            end else begin
               row_in  = row_ff + 1'b1;
               slot_in = slot_nxt;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         slot_ff <= '0;
         nr0_ff  <= '0;
         nc0_ff  <= '0;
         orow_ff <= '0;
         ocol_ff <= '0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         slot_ff <= slot_in;
         nr0_ff  <= nr0_in;
         nc0_ff  <= nc0_in;
         orow_ff <= orow_in;
         ocol_ff <= ocol_in;
      end
   end

endmodule

>>> rtl/mp2d_scan.sv
module mp2d_scan (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mp2d_pkg::cfg_type                     cfg,
   input  logic                                  start,
   input  mp2d_pkg::win_type                     win,
   input  logic                                  take,
   input  logic signed [mp2d_pkg::DATA_BITS-1:0] rd_data,
   output logic                                  rd_en,
   output logic [mp2d_pkg::ADDR_BITS-1:0]        rd_addr,
   output logic                                  busy,
   output mp2d_pkg::res_type                     res
);
   import mp2d_pkg::*;

   scan_state_type state_ff, state_in;

   logic [SLOT_BITS-1:0]        slot_ff, slot_in;
   logic [SLOT_BITS-1:0]        i_ff, i_in;
   logic [SLOT_BITS-1:0]        j_ff, j_in;
   logic [COL_BITS-1:0]         col_ff, col_in;
   logic [COL_BITS-1:0]         c0_ff, c0_in;
   logic [OUT_BITS-1:0]         orow_ff, orow_in;
   logic [OUT_BITS-1:0]         ocol_ff, ocol_in;
   logic                        last_ff, last_in;
   logic                        rd_valid_ff, rd_valid_in;
   logic                        rd_first_ff, rd_first_in;
   logic signed [DATA_BITS-1:0] best_ff, best_in;

   logic i_last, j_last, slot_last;

   always_comb begin
      i_last    = (KER_BITS'(i_ff) + KER_BITS'(1)) == cfg.kheight;
      j_last    = (KER_BITS'(j_ff) + KER_BITS'(1)) == cfg.kwidth;
      slot_last = (KER_BITS'(slot_ff) + KER_BITS'(1)) == cfg.kheight;

      state_in = state_ff;
      slot_in  = slot_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      col_in   = col_ff;
      c0_in    = c0_ff;
      orow_in  = orow_ff;
      ocol_in  = ocol_ff;
      last_in  = last_ff;

      unique case (state_ff)
         SCAN_IDLE: begin
            if (start) begin
               slot_in  = win.slot;
               col_in   = win.c0;
               c0_in    = win.c0;
               i_in     = '0;
               j_in     = '0;
               orow_in  = win.orow;
               ocol_in  = win.ocol;
               last_in  = win.last;
               state_in = SCAN_READ;
            end
         end
         SCAN_READ: begin
            if (j_last) begin
               j_in    = '0;
               col_in  = c0_ff;
               slot_in = slot_last ? '0 : slot_ff + 1'b1;
               i_in    = i_ff + 1'b1;
               if (i_last) begin
                  state_in = SCAN_DRAIN;
               end
            end else begin
               j_in   = j_ff + 1'b1;
               col_in = col_ff + 1'b1;
            end
         end
         SCAN_DRAIN: begin
            state_in = SCAN_EMIT;
         end
         SCAN_EMIT: begin
            if (take) begin
               state_in = SCAN_IDLE;
            end
         end
         default: begin
            state_in = SCAN_IDLE;
         end
      endcase

      rd_en       = state_ff == SCAN_READ;
      rd_addr     = ADDR_BITS'(slot_ff * MAX_WIDTH) + ADDR_BITS'(col_ff);
      rd_valid_in = rd_en;
      rd_first_in = rd_en && (i_ff == '0) && (j_ff == '0);

      // Shared compare unit: one line-store entry per cycle
      best_in = best_ff;
      if (rd_valid_ff && (rd_first_ff || (rd_data > best_ff))) begin
         best_in = rd_data;
      end

      busy       = state_ff != SCAN_IDLE;
      res.valid  = state_ff == SCAN_EMIT;
      res.pooled = best_ff;
      res.orow   = orow_ff;
      res.ocol   = ocol_ff;
      res.last   = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= SCAN_IDLE;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      col_ff      <= col_in;
      c0_ff       <= c0_in;
      orow_ff     <= orow_in;
      ocol_ff     <= ocol_in;
      last_ff     <= last_in;
      rd_first_ff <= rd_first_in;
      best_ff     <= best_in;
   end

endmodule
